/* sv/gkls_pkg.sv */
package gkls_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int MAX_FEATURES = 8;
    localparam int PC_W         = 9;
    localparam int PIDX_W       = 8;
    localparam int FEAT_W       = 3;
    localparam int FC_W         = 4;
    localparam int STORE_AW     = PIDX_W + FEAT_W;
    localparam int DIST_W       = 40;
    localparam int MUL_W        = 33;
    localparam int DIV_DW       = 40;

    localparam logic [31:0] LN2_Q32         = 32'd2977044472;
    localparam logic [63:0] HALF_LN_2PI_Q32 = 64'd3946810947;
    localparam logic [16:0] LOG2E_Q16       = 17'd94548;
    localparam logic [36:0] MV_CAP          = 37'd68719476736;
    localparam logic [63:0] T_LIMIT         = 64'd2097152;

    localparam logic [6:0] DIV_T_BITS    = 7'd56;
    localparam logic [6:0] DIV_TERM_BITS = 7'd33;
    localparam logic [3:0] TAYLOR_TERMS  = 4'd12;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_BW = 1'b0;
    localparam logic REG_FC = 1'b1;

endpackage

/* sv/gkls_mul.sv */
module gkls_mul (
    input  logic                          aclk,
    input  logic [gkls_pkg::MUL_W-1:0]    a,
    input  logic [gkls_pkg::MUL_W-1:0]    b,
    output logic [2*gkls_pkg::MUL_W-1:0]  p
);
    import gkls_pkg::*;

    always_ff @(posedge aclk) begin
        p <= a * b;
    end

endmodule

/* sv/gkls_div.sv */
module gkls_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [63:0]                 num,
    input  logic [gkls_pkg::DIV_DW-1:0] den,
    input  logic [6:0]                  nbits,
    output logic                        done,
    output logic [63:0]                 quo
);
    import gkls_pkg::*;

    logic [63:0]       q_reg;
    logic [DIV_DW:0]   r_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [6:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   r_sh;
    logic              ge;
    logic [DIV_DW:0]   r_new;

    always_comb begin
        r_sh  = {r_reg[DIV_DW-1:0], q_reg[63]};
        ge    = r_sh >= {1'b0, den_reg};
        r_new = ge ? (r_sh - {1'b0, den_reg}) : r_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num << (7'd64 - nbits);
            r_reg   <= '0;
            cnt_reg <= nbits;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[62:0], ge};
            r_reg   <= r_new;
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* sv/gaussian_kde_log_score.sv */
// Loads, clears and non-final query features are taken in the idle state.
// A final query feature runs the scorer: distances for each stored point, the exp sum
// for each point (shared serial divider and multiplier), and three logarithms.
// One item is in work at a time; the input is not ready while scoring runs.
// Synchronous active-low reset clears counters and the output valid, and sets bandwidth to 256 and feature count to 1.
module gaussian_kde_log_score (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // log_density
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import gkls_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_DEN   = 5'd1,  S_DENW  = 5'd2,
                           S_D_RD  = 5'd3,  S_D_MUL = 5'd4,  S_D_ACC = 5'd5,
                           S_D_END = 5'd6,  S_MV_GO = 5'd7,  S_MV_W  = 5'd8,
                           S_E_RD  = 5'd9,  S_E_GO  = 5'd10, S_E_DW  = 5'd11,
                           S_E_U   = 5'd12, S_E_UW  = 5'd13, S_E_YW  = 5'd14,
                           S_T_MUL = 5'd15, S_T_MW  = 5'd16, S_T_DW  = 5'd17,
                           S_E_ACC = 5'd18, S_E_NXT = 5'd19, S_L_GO  = 5'd20,
                           S_L_NRM = 5'd21, S_L_SQ  = 5'd22, S_L_SQW = 5'd23,
                           S_L_FR  = 5'd24, S_L_FRW = 5'd25, S_L_PW  = 5'd26,
                           S_NF    = 5'd27, S_FIN   = 5'd28;

    localparam logic [1:0] R_BW = 2'd0, R_N = 2'd1, R_S = 2'd2;

    logic [4:0]          state_reg;
    logic [15:0]         bw_reg;
    logic [FC_W-1:0]     fc_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [FEAT_W-1:0]   lfi_reg;
    logic [FEAT_W-1:0]   qfi_reg;
    logic [15:0]         qbuf_reg [MAX_FEATURES];

    logic [PC_W-1:0]     j_reg;
    logic [FC_W-1:0]     f_reg;
    logic [3:0]          nt_reg;
    logic [4:0]          sq_reg;
    logic [DIST_W-1:0]   den_reg;
    logic [DIST_W-1:0]   d_reg;
    logic [DIST_W-1:0]   dmin_reg;
    logic [36:0]         mv_reg;
    logic [20:0]         t_reg;
    logic [5:0]          k_reg;
    logic [31:0]         y_reg;
    logic [32:0]         term_reg;
    logic signed [34:0]  acc_reg;
    logic [40:0]         s_reg;
    logic [40:0]         x_reg;
    logic [40:0]         sh_reg;
    logic [5:0]          lp_reg;
    logic [30:0]         m_reg;
    logic [29:0]         frac_reg;
    logic [63:0]         lnv_reg;
    logic [1:0]          ret_reg;
    logic signed [63:0]  tot_reg;
    logic signed [63:0]  sub_reg;

    logic                m_valid_reg;
    logic [31:0]         m_data_reg;
    logic [1:0]          m_user_reg;

    logic [15:0]         store_mem [MAX_POINTS*MAX_FEATURES];
    logic [15:0]         store_rd;
    logic [DIST_W-1:0]   dist_mem [MAX_POINTS];
    logic [DIST_W-1:0]   dist_rd;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic                div_start;
    logic [63:0]         div_num;
    logic [DIV_DW-1:0]   div_den;
    logic [6:0]          div_nbits;
    logic                div_done;
    logic [63:0]         div_q;

    logic [FC_W-1:0]     nf;
    logic [15:0]         bwe;
    logic                acc_in;
    logic                out_free;
    logic [FEAT_W-1:0]   lfi_eff;
    logic [FEAT_W-1:0]   qfi_eff;
    logic [FC_W-1:0]     lfi_inc;
    logic [FC_W-1:0]     qfi_inc;
    logic                store_we;
    logic signed [16:0]  diff;
    logic [16:0]         mag;
    logic [DIST_W-1:0]   dd;
    logic [31:0]         mm;
    logic [63:0]         ln_res;
    logic signed [63:0]  rnd;
    logic signed [63:0]  sh16;
    logic [31:0]         sat;

    gkls_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    gkls_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .nbits(div_nbits), .done(div_done), .quo(div_q)
    );

    always_comb begin
        if (fc_reg == '0) begin
            nf = FC_W'(1);
        end else if (fc_reg > FC_W'(MAX_FEATURES)) begin
            nf = FC_W'(MAX_FEATURES);
        end else begin
            nf = fc_reg;
        end
        bwe      = (bw_reg == 16'd0) ? 16'd1 : bw_reg;
        out_free = !m_valid_reg || m_tready;
        s_tready = (state_reg == S_IDLE) && out_free;
        acc_in   = s_tvalid && s_tready;
        lfi_eff  = ({1'b0, lfi_reg} >= nf) ? '0 : lfi_reg;
        qfi_eff  = ({1'b0, qfi_reg} >= nf) ? '0 : qfi_reg;
        lfi_inc  = {1'b0, lfi_eff} + FC_W'(1);
        qfi_inc  = {1'b0, qfi_eff} + FC_W'(1);
        store_we = acc_in && s_tuser == OP_LOAD && pc_reg < PC_W'(MAX_POINTS);
        diff     = $signed({qbuf_reg[f_reg[FEAT_W-1:0]][15], qbuf_reg[f_reg[FEAT_W-1:0]]})
                 - $signed({store_rd[15], store_rd});
        mag      = diff[16] ? 17'(-diff) : 17'(diff);
        dd       = dist_rd - dmin_reg;
        mm       = mul_p[61:30];
        ln_res   = mul_p[63:0] + lnv_reg;
        rnd      = tot_reg + 64'sd32768;
        sh16     = rnd >>> 16;
        if (sh16 > 64'sd2147483647) begin
            sat = 32'h7FFF_FFFF;
        end else if (sh16 < -64'sd2147483648) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sh16[31:0];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DEN: begin
                mul_a = {17'd0, bwe};
                mul_b = {17'd0, bwe};
            end
            S_D_MUL: begin
                mul_a = {16'd0, mag};
                mul_b = {16'd0, mag};
            end
            S_E_U: begin
                mul_a = {12'd0, t_reg};
                mul_b = {16'd0, LOG2E_Q16};
            end
            S_E_UW: begin
                mul_a = {1'b0, mul_p[31:0]};
                mul_b = {1'b0, LN2_Q32};
            end
            S_T_MUL: begin
                mul_a = term_reg;
                mul_b = {1'b0, y_reg};
            end
            S_L_SQ: begin
                mul_a = {2'd0, m_reg};
                mul_b = {2'd0, m_reg};
            end
            S_L_FR: begin
                mul_a = {3'd0, frac_reg};
                mul_b = {1'b0, LN2_Q32};
            end
            S_L_FRW: begin
                mul_a = {27'd0, lp_reg};
                mul_b = {1'b0, LN2_Q32};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = den_reg;
        div_nbits = DIV_T_BITS;
        case (state_reg)
            S_MV_GO: begin
                div_start = 1'b1;
                div_num   = {8'd0, dmin_reg, 16'd0};
            end
            S_E_GO: begin
                div_start = 1'b1;
                div_num   = {8'd0, dd, 16'd0};
            end
            S_T_MW: begin
                div_start = 1'b1;
                div_num   = {31'd0, mul_p[64:32]};
                div_den   = {36'd0, nt_reg};
                div_nbits = DIV_TERM_BITS;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[{pc_reg[PIDX_W-1:0], lfi_eff}] <= s_tdata;
        end
        store_rd <= store_mem[{j_reg[PIDX_W-1:0], f_reg[FEAT_W-1:0]}];
        if (state_reg == S_D_END) begin
            dist_mem[j_reg[PIDX_W-1:0]] <= d_reg;
        end
        dist_rd <= dist_mem[j_reg[PIDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bw_reg      <= 16'd256;
            fc_reg      <= FC_W'(1);
            pc_reg      <= '0;
            lfi_reg     <= '0;
            qfi_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_addr == REG_BW) begin
                    bw_reg <= cfg_wdata;
                end else begin
                    fc_reg  <= cfg_wdata[FC_W-1:0];
                    lfi_reg <= '0;
                    qfi_reg <= '0;
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc_in) begin
                        case (s_tuser)
                            OP_CLEAR: begin
                                pc_reg  <= '0;
                                lfi_reg <= '0;
                            end
                            OP_LOAD: begin
                                if (pc_reg >= PC_W'(MAX_POINTS)) begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= '0;
                                    m_user_reg  <= ST_FULL;
                                end else if (lfi_inc >= nf) begin
                                    lfi_reg <= '0;
                                    pc_reg  <= pc_reg + PC_W'(1);
                                end else begin
                                    lfi_reg <= lfi_inc[FEAT_W-1:0];
                                end
                            end
                            OP_QUERY: begin
                                qbuf_reg[qfi_eff] <= s_tdata;
                                if (qfi_inc < nf) begin
                                    qfi_reg <= qfi_inc[FEAT_W-1:0];
                                end else begin
                                    qfi_reg <= '0;
                                    if (pc_reg == '0) begin
                                        m_valid_reg <= 1'b1;
                                        m_data_reg  <= '0;
                                        m_user_reg  <= ST_EMPTY;
                                    end else begin
                                        j_reg     <= '0;
                                        f_reg     <= '0;
                                        d_reg     <= '0;
                                        dmin_reg  <= '1;
                                        state_reg <= S_DEN;
                                    end
                                end
                            end
                            default: begin
                                pc_reg <= pc_reg;
                            end
                        endcase
                    end
                end
                S_DEN: state_reg <= S_DENW;
                S_DENW: begin
                    den_reg   <= {mul_p[38:0], 1'b0};
                    state_reg <= S_D_RD;
                end
                S_D_RD: state_reg <= S_D_MUL;
                S_D_MUL: state_reg <= S_D_ACC;
                S_D_ACC: begin
                    d_reg <= d_reg + {8'd0, mul_p[31:0]};
                    if (f_reg + FC_W'(1) == nf) begin
                        state_reg <= S_D_END;
                    end else begin
                        f_reg     <= f_reg + FC_W'(1);
                        state_reg <= S_D_RD;
                    end
                end
                S_D_END: begin
                    if (d_reg < dmin_reg) begin
                        dmin_reg <= d_reg;
                    end
                    f_reg <= '0;
                    d_reg <= '0;
                    if (j_reg + PC_W'(1) == pc_reg) begin
                        state_reg <= S_MV_GO;
                    end else begin
                        j_reg     <= j_reg + PC_W'(1);
                        state_reg <= S_D_RD;
                    end
                end
                S_MV_GO: state_reg <= S_MV_W;
                S_MV_W: begin
                    if (div_done) begin
                        mv_reg    <= (div_q > {27'd0, MV_CAP}) ? MV_CAP : div_q[36:0];
                        j_reg     <= '0;
                        s_reg     <= '0;
                        state_reg <= S_E_RD;
                    end
                end
                S_E_RD: state_reg <= S_E_GO;
                S_E_GO: state_reg <= S_E_DW;
                S_E_DW: begin
                    if (div_done) begin
                        if (div_q >= T_LIMIT) begin
                            state_reg <= S_E_NXT;
                        end else begin
                            t_reg     <= div_q[20:0];
                            state_reg <= S_E_U;
                        end
                    end
                end
                S_E_U: state_reg <= S_E_UW;
                S_E_UW: begin
                    k_reg     <= mul_p[37:32];
                    state_reg <= S_E_YW;
                end
                S_E_YW: begin
                    y_reg     <= mul_p[63:32];
                    term_reg  <= 33'h1_0000_0000;
                    acc_reg   <= 35'sh1_0000_0000;
                    nt_reg    <= 4'd1;
                    state_reg <= S_T_MUL;
                end
                S_T_MUL: state_reg <= S_T_MW;
                S_T_MW: state_reg <= S_T_DW;
                S_T_DW: begin
                    if (div_done) begin
                        term_reg <= div_q[32:0];
                        if (nt_reg[0]) begin
                            acc_reg <= acc_reg - $signed({2'b00, div_q[32:0]});
                        end else begin
                            acc_reg <= acc_reg + $signed({2'b00, div_q[32:0]});
                        end
                        if (nt_reg == TAYLOR_TERMS) begin
                            state_reg <= S_E_ACC;
                        end else begin
                            nt_reg    <= nt_reg + 4'd1;
                            state_reg <= S_T_MUL;
                        end
                    end
                end
                S_E_ACC: begin
                    s_reg     <= s_reg + {8'd0, acc_reg[32:0] >> k_reg};
                    state_reg <= S_E_NXT;
                end
                S_E_NXT: begin
                    if (j_reg + PC_W'(1) == pc_reg) begin
                        x_reg     <= {25'd0, bwe};
                        ret_reg   <= R_BW;
                        state_reg <= S_L_GO;
                    end else begin
                        j_reg     <= j_reg + PC_W'(1);
                        state_reg <= S_E_RD;
                    end
                end
                S_L_GO: begin
                    sh_reg    <= x_reg;
                    lp_reg    <= 6'd40;
                    state_reg <= S_L_NRM;
                end
                S_L_NRM: begin
                    if (sh_reg[40]) begin
                        m_reg     <= sh_reg[40:10];
                        frac_reg  <= '0;
                        sq_reg    <= '0;
                        state_reg <= S_L_SQ;
                    end else begin
                        sh_reg <= {sh_reg[39:0], 1'b0};
                        lp_reg <= lp_reg - 6'd1;
                    end
                end
                S_L_SQ: state_reg <= S_L_SQW;
                S_L_SQW: begin
                    if (mm[31]) begin
                        m_reg    <= mm[31:1];
                        frac_reg <= {frac_reg[28:0], 1'b1};
                    end else begin
                        m_reg    <= mm[30:0];
                        frac_reg <= {frac_reg[28:0], 1'b0};
                    end
                    if (sq_reg == 5'd29) begin
                        state_reg <= S_L_FR;
                    end else begin
                        sq_reg    <= sq_reg + 5'd1;
                        state_reg <= S_L_SQ;
                    end
                end
                S_L_FR: state_reg <= S_L_FRW;
                S_L_FRW: begin
                    lnv_reg   <= {34'd0, mul_p[59:30]} + {32'd0, mul_p[61:60], 30'd0};
                    state_reg <= S_L_PW;
                end
                S_L_PW: begin
                    case (ret_reg)
                        R_BW: begin
                            sub_reg   <= $signed(HALF_LN_2PI_Q32 + ln_res
                                         - {29'd0, LN2_Q32, 3'd0});
                            x_reg     <= {32'd0, pc_reg};
                            ret_reg   <= R_N;
                            state_reg <= S_L_GO;
                        end
                        R_N: begin
                            tot_reg   <= $signed(64'd0 - ln_res - {11'd0, mv_reg, 16'd0}
                                         - {27'd0, LN2_Q32, 5'd0});
                            x_reg     <= s_reg;
                            ret_reg   <= R_S;
                            state_reg <= S_L_GO;
                        end
                        default: begin
                            tot_reg   <= tot_reg + $signed(ln_res);
                            f_reg     <= '0;
                            state_reg <= S_NF;
                        end
                    endcase
                end
                S_NF: begin
                    tot_reg <= tot_reg - sub_reg;
                    if (f_reg + FC_W'(1) == nf) begin
                        state_reg <= S_FIN;
                    end else begin
                        f_reg <= f_reg + FC_W'(1);
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= sat;
                        m_user_reg  <= ST_OK;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* sv/gkls_chk.sv */
module gkls_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import gkls_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 32'd0)
        else $error("error result carries nonzero density");

    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL)
        else $error("unknown status code");

endmodule

bind gaussian_kde_log_score gkls_chk u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
